// File: rtl/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and sizes for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

endpackage
`default_nettype wire

// File: rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (get or put, key, value) enter on the i_in_valid/o_in_ready
//   channel; one response per request leaves on o_out_valid/i_out_ready.
//   A request is held in the input register; once the response register is
//   free or being taken, the parallel key compare over all entries, the
//   value/victim select and the recency-rank update run and load the response
//   register, with o_out_valid registered alongside. One transaction per cycle
//   while the receiver does not stall, set by the rank update loop.
//   When the receiver stalls, the response register holds and the input
//   register still takes one more transaction, then o_in_ready drops.
//   The capacity register is written over i_cfg_valid/o_cfg_ready (always
//   ready); a write is ignored unless the cache is empty. Values 0 and
//   above the entry count saturate to 1 and the entry count.
//   Reset (synchronous, active low) empties the cache, clears all ranks and
//   sets capacity to the full entry count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire t_req             i_in,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      t_rsp             o_out,
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    logic                    r_in_valid;
    t_req                    r_req;
    logic                    r_out_valid;
    t_rsp                    r_rsp;
    logic [CNT_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_occ;
    logic [MAX_ENTRIES-1:0]  r_valid;
    logic [IDX_W-1:0]        r_rank [MAX_ENTRIES];
    logic [KEY_W-1:0]        r_key  [MAX_ENTRIES];
    logic [VAL_W-1:0]        r_val  [MAX_ENTRIES];

    logic                    w_proc;
    logic [MAX_ENTRIES-1:0]  w_match;
    logic [MAX_ENTRIES-1:0]  w_victim;
    logic [MAX_ENTRIES-1:0]  w_free;
    logic [MAX_ENTRIES-1:0]  w_promote;
    logic [MAX_ENTRIES-1:0]  w_key_we;
    logic [MAX_ENTRIES-1:0]  w_val_we;
    logic [IDX_W-1:0]        w_free_idx;
    logic [IDX_W-1:0]        w_hit_rank;
    logic [IDX_W-1:0]        w_lru_rank;
    logic [IDX_W-1:0]        w_promote_rank;
    logic [VAL_W-1:0]        w_hit_val;
    logic [KEY_W-1:0]        w_victim_key;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_insert;
    logic                    w_evict;
    logic [MAX_ENTRIES-1:0]  n_valid;
    logic [IDX_W-1:0]        n_rank [MAX_ENTRIES];
    logic [CNT_W-1:0]        n_occ;
    logic [CNT_W-1:0]        n_cap;
    t_rsp                    n_rsp;

    assign w_proc      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_proc;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_rsp;
    assign o_cfg_ready = 1'b1;

    // capacity clamp
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(MAX_ENTRIES)) begin
            n_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    // Valid ranks form a permutation of 0..occ-1, so the LRU entry is the
    // one ranked occ-1.
    assign w_lru_rank = IDX_W'(r_occ - CNT_W'(1));
    assign w_full     = (r_occ >= r_cap);

    always_comb begin
        w_hit_rank   = '0;
        w_hit_val    = '0;
        w_victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i]  = r_valid[i] && (r_key[i] == r_req.key);
            w_victim[i] = r_valid[i] && (r_rank[i] == w_lru_rank);
            if (w_match[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
                w_hit_val  = w_hit_val | r_val[i];
            end
            if (w_victim[i]) begin
                w_victim_key = w_victim_key | r_key[i];
            end
        end
        w_free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_free[i] = (w_free_idx == IDX_W'(i));
        end
    end

    assign w_hit          = |w_match;
    assign w_evict        = !w_hit && (r_req.op == OP_PUT) && w_full;
    assign w_insert       = !w_hit && (r_req.op == OP_PUT) && !w_full;
    assign w_promote      = w_hit ? w_match : (w_evict ? w_victim : '0);
    assign w_promote_rank = w_hit ? w_hit_rank : w_lru_rank;

    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i]   = r_rank[i];
            w_key_we[i] = 1'b0;
            w_val_we[i] = 1'b0;
            if (w_insert) begin
                if (w_free[i]) begin
                    n_valid[i]  = 1'b1;
                    n_rank[i]   = '0;
                    w_key_we[i] = 1'b1;
                    w_val_we[i] = 1'b1;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end else if (w_promote != '0) begin
                if (w_promote[i]) begin
                    n_rank[i]   = '0;
                    w_key_we[i] = w_evict;
                    w_val_we[i] = (r_req.op == OP_PUT);
                end else if (r_valid[i] && (r_rank[i] < w_promote_rank)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
        end
        if (w_insert) begin
            n_occ = r_occ + CNT_W'(1);
        end

        n_rsp.hit         = w_hit;
        n_rsp.read_value  = (w_hit && (r_req.op == OP_GET)) ? w_hit_val : '0;
        n_rsp.evicted     = w_evict;
        n_rsp.evicted_key = w_evict ? w_victim_key : '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CNT_W'(MAX_ENTRIES);
            r_occ       <= '0;
            r_valid     <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && (r_occ == '0)) begin
                r_cap <= n_cap;
            end
            if (w_proc) begin
                r_occ   <= n_occ;
                r_valid <= n_valid;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // payload and entry storage
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in;
        end
        if (w_proc) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (w_key_we[i]) begin
                    r_key[i] <= r_req.key;
                end
                if (w_val_we[i]) begin
                    r_val[i] <= r_req.value;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. Capacity writes at the
// extremes are made while the cache is empty, and later ones while it is not.
// A short directed table comes next, then random get/put traffic over a small
// key pool under four pacing phases. Every response is checked against an
// in-bench LRU model, or against the row's own response for typed table rows.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int POOL_MAX = 24;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_cache_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_req             i_in = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_rsp             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;

    // side info that travels with the request on the input channel
    bit   row_typed = 1'b0;
    t_rsp row_rsp = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int errors = 0;
    int n_req = 0;
    int n_hit = 0;
    int n_evict = 0;

    // LRU model state
    logic [KEY_W-1:0] m_key [MAX_ENTRIES];
    logic [VAL_W-1:0] m_val [MAX_ENTRIES];
    bit               m_valid [MAX_ENTRIES] = '{default: 1'b0};
    int               m_rank [MAX_ENTRIES] = '{default: 0};
    int               m_count = 0;
    int               m_capacity = MAX_ENTRIES;

    t_rsp       owed_responses[$];
    t_cache_row directed_rows[$];

    lru_key_value_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // move slot s to rank 0; entries newer than its old rank age by one
    function automatic void make_newest(int s);
        int old_rank;
        old_rank = m_rank[s];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (m_valid[i] && i != s && m_rank[i] < old_rank) begin
                m_rank[i]++;
            end
        end
        m_rank[s] = 0;
    endfunction

    function automatic t_rsp lru_access(t_req rq);
        t_rsp r;
        int   found;
        int   slot;
        int   worst;
        r = '0;
        found = -1;
        slot = -1;
        worst = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (found < 0 && m_valid[i] && m_key[i] == rq.key) begin
                found = i;
            end
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            if (rq.op == OP_GET) begin
                r.read_value = m_val[found];
            end else begin
                m_val[found] = rq.value;
            end
            make_newest(found);
        end else if (rq.op == OP_PUT) begin
            if (m_count >= m_capacity) begin
                // victim is the valid entry with the highest rank
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (m_valid[i] && (slot < 0 || m_rank[i] > worst)) begin
                        slot = i;
                        worst = m_rank[i];
                    end
                end
                r.evicted = 1'b1;
                r.evicted_key = m_key[slot];
                m_key[slot] = rq.key;
                m_val[slot] = rq.value;
                make_newest(slot);
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (slot < 0 && !m_valid[i]) begin
                        slot = i;
                    end
                end
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (m_valid[i]) begin
                        m_rank[i]++;
                    end
                end
                m_valid[slot] = 1'b1;
                m_key[slot] = rq.key;
                m_val[slot] = rq.value;
                m_rank[slot] = 0;
                m_count++;
            end
        end
        return r;
    endfunction

    // monitor: capacity writes, request predictions, response checks
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && m_count == 0) begin
                if (i_cfg_data == 0) begin
                    m_capacity = 1;
                end else if (i_cfg_data > MAX_ENTRIES) begin
                    m_capacity = MAX_ENTRIES;
                end else begin
                    m_capacity = i_cfg_data;
                end
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out;
                if (owed_responses.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response %p", $time, got);
                end else begin
                    want = owed_responses.pop_front();
                    if (want.hit !== got.hit) begin
                        errors++;
                        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                    end
                    if (want.read_value !== got.read_value) begin
                        errors++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, got.read_value);
                    end
                    if (want.evicted !== got.evicted) begin
                        errors++;
                        $display("%0t: evicted expected %0d actual %0d",
                                 $time, want.evicted, got.evicted);
                    end
                    if (want.evicted_key !== got.evicted_key) begin
                        errors++;
                        $display("%0t: evicted_key expected %h actual %h",
                                 $time, want.evicted_key, got.evicted_key);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = lru_access(i_in);
                if (row_typed) begin
                    want = row_rsp;
                end
                n_req++;
                n_hit += want.hit;
                n_evict += want.evicted;
                owed_responses.push_back(want);
            end
        end
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_lru_key_value_cache failed");
        $finish;
    end

    // entered and left at a rising edge; returns on the accepting edge
    task automatic send_request(input t_req rq, input bit typed, input t_rsp rsp);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= rq;
        row_typed <= typed;
        row_rsp <= rsp;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // i_cfg_valid is dropped and left idle before returning, so back-to-back calls stay clean
    task automatic write_capacity(input logic [CNT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_responses.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic op, input logic [31:0] key, input logic [31:0] value,
                           input bit typed, input t_rsp rsp);
        t_cache_row r;
        r.req.op = op;
        r.req.key = key;
        r.req.value = value;
        r.typed = typed;
        r.rsp = rsp;
        directed_rows.push_back(r);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] key_pool [POOL_MAX];
        int          pool_n;
        t_req        rq;
        t_rsp        none;
        none = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // capacity extremes while empty, then the setting for the run
        write_capacity(5'd0);
        write_capacity(5'd31);
        write_capacity(5'd17);
        case ($urandom_range(0, 2))
            0: write_capacity(5'd1);
            1: write_capacity(5'd16);
            default: write_capacity(5'($urandom_range(2, 15)));
        endcase

        add_row(OP_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, none);
        add_row(OP_GET, 32'h8000_0000, 32'hffff_ffff, 1'b1, none);
        add_row(OP_PUT, 32'h0000_0000, 32'h7fff_ffff, 1'b1, none);
        add_row(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                t_rsp'{hit: 1'b1, read_value: 32'h7fff_ffff, evicted: 1'b0, evicted_key: '0});
        // key one bit away from a stored one must miss
        add_row(OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, none);
        // put hit overwrites and reports no read data
        add_row(OP_PUT, 32'h0000_0000, 32'h8000_0000, 1'b1,
                t_rsp'{hit: 1'b1, read_value: '0, evicted: 1'b0, evicted_key: '0});
        add_row(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                t_rsp'{hit: 1'b1, read_value: 32'h8000_0000, evicted: 1'b0, evicted_key: '0});
        add_row(OP_PUT, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, none);
        add_row(OP_PUT, 32'h8000_0000, 32'h0000_0000, 1'b0, none);
        add_row(OP_PUT, 32'hffff_ffff, 32'h1234_5678, 1'b0, none);
        // fill past a full cache so the oldest entries are evicted
        for (int i = 0; i < 13; i++) begin
            add_row(OP_PUT, 32'h0000_0010 + i, 32'hc0de_0000 + i, 1'b0, none);
        end
        add_row(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, none);
        add_row(OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0, none);
        add_row(OP_PUT, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b0, none);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        end
        wait_drained();
        // cache is no longer empty: this write must not take effect
        write_capacity(5'd1);

        pool_n = m_capacity + 3;
        foreach (key_pool[i]) begin
            key_pool[i] = pick_word();
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    key_pool[$urandom_range(0, pool_n - 1)] = $urandom;
                end
                rq.op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                rq.key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, pool_n - 1)]
                                                      : pick_word();
                rq.value = pick_word();
                send_request(rq, 1'b0, none);
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
            write_capacity(5'($urandom_range(0, 31)));
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests, %0d hits, %0d evictions at capacity %0d",
                 n_req, n_hit, n_evict, m_capacity);
        $display("four pacing phases: free run, sender gaps, receiver stalls, both");
        if (errors == 0) begin
            $display("tb_lru_key_value_cache passed");
        end else begin
            $display("tb_lru_key_value_cache failed");
        end
        $finish;
    end

endmodule
